FILE: rtl/core/hcd_pkg.sv
// Hill car dynamics step: shared types, constants and the sub-step microprogram.
// No dependencies; used by every module of the core.
`timescale 1ns / 1ps

package hcd_pkg;

    localparam int Q_W    = 32;
    localparam int CFG_W  = 31;
    localparam int RWD_W  = 25;
    localparam int DIV_N  = 56;
    localparam int SQ_N   = 28;
    localparam int PC_W   = 6;

    localparam int NUM_ACTIONS_DEF = 2;
    localparam int SUB_STEPS_DEF   = 100;

    localparam logic signed [Q_W-1:0] Q_ONE  = 32'sd16777216;
    localparam logic signed [Q_W-1:0] Q_TWO  = 32'sd33554432;
    localparam logic signed [Q_W-1:0] Q_DT   = 32'sd16777;
    localparam logic signed [Q_W-1:0] Q_MAX  = 32'sh7FFFFFFF;
    localparam logic signed [Q_W-1:0] Q_MIN  = 32'sh80000000;

    localparam logic [CFG_W-1:0] GRAVITY_RST   = 31'd164584489;
    localparam logic [CFG_W-1:0] CAR_MASS_RST  = 31'd16777216;
    localparam logic [CFG_W-1:0] MAX_SPEED_RST = 31'd50331648;
    localparam logic [CFG_W-1:0] MAX_ACCEL_RST = 31'd67108864;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAR_MASS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL = 2'd3;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_GOAL = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    localparam logic [2:0] OP_KMA  = 3'd0;
    localparam logic [2:0] OP_SUB3 = 3'd1;
    localparam logic [2:0] OP_SEL  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_SQRT = 3'd5;
    localparam logic [2:0] OP_ACC  = 3'd6;

    localparam logic [4:0] R_X    = 5'd0;
    localparam logic [4:0] R_V    = 5'd1;
    localparam logic [4:0] R_ACC  = 5'd2;
    localparam logic [4:0] R_DP   = 5'd3;
    localparam logic [4:0] R_XS   = 5'd4;
    localparam logic [4:0] R_T    = 5'd5;
    localparam logic [4:0] R_R    = 5'd6;
    localparam logic [4:0] R_X4   = 5'd7;
    localparam logic [4:0] R_X6   = 5'd8;
    localparam logic [4:0] R_D1   = 5'd9;
    localparam logic [4:0] R_D2   = 5'd10;
    localparam logic [4:0] R_HP1  = 5'd11;
    localparam logic [4:0] R_HPP1 = 5'd12;
    localparam logic [4:0] R_HP   = 5'd13;
    localparam logic [4:0] R_HPP  = 5'd14;
    localparam logic [4:0] R_HPS  = 5'd15;
    localparam logic [4:0] R_T1   = R_X4;
    localparam logic [4:0] R_T2   = R_X6;
    localparam logic [4:0] R_T3   = R_D1;
    localparam logic [4:0] S_ZERO = 5'd16;
    localparam logic [4:0] S_ONE  = 5'd17;
    localparam logic [4:0] S_TWO  = 5'd18;
    localparam logic [4:0] S_DT   = 5'd19;
    localparam logic [4:0] S_G    = 5'd20;
    localparam logic [4:0] S_MS   = 5'd21;
    localparam logic [4:0] S_INX  = 5'd22;
    localparam logic [4:0] S_INV  = 5'd23;

    localparam logic [PC_W-1:0] PC_BODY = 6'd3;
    localparam logic [PC_W-1:0] PC_LAST = 6'd35;

    typedef struct packed {
        logic signed [Q_W-1:0] position;
        logic signed [Q_W-1:0] velocity;
        logic [1:0]            status;
        logic [0:0]            action_index;
    } in_t;

    typedef struct packed {
        logic signed [Q_W-1:0] next_position;
        logic signed [Q_W-1:0] next_velocity;
        logic [1:0]            next_status;
        logic [RWD_W-1:0]      reward;
    } out_t;

    typedef struct packed {
        logic [CFG_W-1:0] gravity;
        logic [CFG_W-1:0] car_mass;
        logic [CFG_W-1:0] max_speed;
        logic [CFG_W-1:0] max_accel;
    } cfg_t;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] k;
        logic [4:0] ra;
        logic [4:0] rb;
        logic [4:0] rc;
        logic [4:0] rd;
    } uop_t;

    typedef struct packed {
        logic load_in;
        logic rd_ab;
        logic rd_c;
        logic start;
        logic out_load;
        uop_t uop;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic term;
    } sts_t;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 64'(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < 64'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic uop_t mk(input logic [2:0] op, input logic [6:0] k,
                                input logic [4:0] ra, input logic [4:0] rb,
                                input logic [4:0] rc, input logic [4:0] rd);
        uop_t u;
        u.op = op;
        u.k  = k;
        u.ra = ra;
        u.rb = rb;
        u.rc = rc;
        u.rd = rd;
        return u;
    endfunction

    function automatic uop_t prog(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            6'd0:  u = mk(OP_KMA,  7'd1,   S_INX,  S_ZERO, S_ZERO, R_X);
            6'd1:  u = mk(OP_KMA,  7'd1,   S_INV,  S_ZERO, S_ZERO, R_V);
            6'd2:  u = mk(OP_ACC,  7'd0,   S_ZERO, S_ZERO, S_ZERO, R_ACC);
            6'd3:  u = mk(OP_MUL,  7'd0,   S_DT,   R_V,    S_ZERO, R_DP);
            6'd4:  u = mk(OP_MUL,  7'd0,   R_X,    R_X,    S_ZERO, R_XS);
            6'd5:  u = mk(OP_KMA,  7'd5,   R_XS,   S_ONE,  S_ZERO, R_T);
            6'd6:  u = mk(OP_SQRT, 7'd0,   R_T,    S_ZERO, S_ZERO, R_R);
            6'd7:  u = mk(OP_MUL,  7'd0,   R_XS,   R_XS,   S_ZERO, R_X4);
            6'd8:  u = mk(OP_MUL,  7'd0,   R_X4,   R_XS,   S_ZERO, R_X6);
            6'd9:  u = mk(OP_KMA,  7'd25,  R_X4,   S_ONE,  S_ZERO, R_T);
            6'd10: u = mk(OP_KMA,  7'd10,  R_XS,   R_T,    S_ZERO, R_D1);
            6'd11: u = mk(OP_KMA,  7'd125, R_X6,   S_ONE,  S_ZERO, R_T);
            6'd12: u = mk(OP_KMA,  7'd75,  R_X4,   R_T,    S_ZERO, R_T);
            6'd13: u = mk(OP_KMA,  7'd15,  R_XS,   R_T,    S_ZERO, R_D2);
            6'd14: u = mk(OP_DIV,  7'd0,   R_R,    R_D1,   S_ZERO, R_HP1);
            6'd15: u = mk(OP_KMA,  7'd15,  R_X,    S_ZERO, S_ZERO, R_T);
            6'd16: u = mk(OP_MUL,  7'd0,   R_T,    R_R,    S_ZERO, R_T);
            6'd17: u = mk(OP_DIV,  7'd0,   R_T,    R_D2,   S_ZERO, R_T);
            6'd18: u = mk(OP_SUB3, 7'd0,   S_ZERO, R_T,    S_ZERO, R_HPP1);
            6'd19: u = mk(OP_KMA,  7'd2,   R_X,    S_ONE,  S_ZERO, R_T);
            6'd20: u = mk(OP_SEL,  7'd0,   R_T,    R_HP1,  S_ZERO, R_HP);
            6'd21: u = mk(OP_SEL,  7'd0,   S_TWO,  R_HPP1, S_ZERO, R_HPP);
            6'd22: u = mk(OP_MUL,  7'd0,   R_HP,   R_HP,   S_ZERO, R_T);
            6'd23: u = mk(OP_KMA,  7'd1,   R_T,    S_ONE,  S_ZERO, R_HPS);
            6'd24: u = mk(OP_MUL,  7'd0,   S_MS,   R_HPS,  S_ZERO, R_T);
            6'd25: u = mk(OP_DIV,  7'd0,   R_ACC,  R_T,    S_ZERO, R_T1);
            6'd26: u = mk(OP_MUL,  7'd0,   S_G,    R_HP,   S_ZERO, R_T);
            6'd27: u = mk(OP_DIV,  7'd0,   R_T,    R_HPS,  S_ZERO, R_T2);
            6'd28: u = mk(OP_MUL,  7'd0,   R_V,    R_V,    S_ZERO, R_T);
            6'd29: u = mk(OP_MUL,  7'd0,   R_T,    R_HP,   S_ZERO, R_T);
            6'd30: u = mk(OP_MUL,  7'd0,   R_T,    R_HPP,  S_ZERO, R_T);
            6'd31: u = mk(OP_DIV,  7'd0,   R_T,    R_HPS,  S_ZERO, R_T3);
            6'd32: u = mk(OP_SUB3, 7'd0,   R_T1,   R_T2,   R_T3,   R_T);
            6'd33: u = mk(OP_MUL,  7'd0,   S_DT,   R_T,    S_ZERO, R_T);
            6'd34: u = mk(OP_KMA,  7'd1,   R_X,    R_DP,   S_ZERO, R_X);
            6'd35: u = mk(OP_KMA,  7'd1,   R_V,    R_T,    S_ZERO, R_V);
            default: u = mk(OP_KMA, 7'd0,  S_ZERO, S_ZERO, S_ZERO, R_T);
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/core/hill_car_dynamics_step_core.sv
// A terminal input passes from IDLE through CHECK to DONE and is then loaded into the output
// register; a running input takes SUB_STEPS passes of the microprogram body, each with five
// radix-2 divisions (a zero divisor writes its saturated result without iterating) and one square root.
// Throughput: one item at a time; the next item is taken while a result waits on m_valid.
// Reset: aresetn synchronous active low; restores register defaults and empties the output.
// Depends on hcd_pkg, hcd_ctrl and hcd_dpath.
`timescale 1ns / 1ps

module hill_car_dynamics_step_core #(
    parameter int NUM_ACTIONS = hcd_pkg::NUM_ACTIONS_DEF,
    parameter int SUB_STEPS   = hcd_pkg::SUB_STEPS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  hcd_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output hcd_pkg::out_t                   m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hcd_pkg::CFG_W-1:0]       cfg_data
);

    hcd_pkg::cfg_t cfg_reg;
    hcd_pkg::cmd_t cmd;
    hcd_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gravity   <= hcd_pkg::GRAVITY_RST;
            cfg_reg.car_mass  <= hcd_pkg::CAR_MASS_RST;
            cfg_reg.max_speed <= hcd_pkg::MAX_SPEED_RST;
            cfg_reg.max_accel <= hcd_pkg::MAX_ACCEL_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                hcd_pkg::CFG_GRAVITY:   cfg_reg.gravity   <= cfg_data;
                hcd_pkg::CFG_CAR_MASS:  cfg_reg.car_mass  <= cfg_data;
                hcd_pkg::CFG_MAX_SPEED: cfg_reg.max_speed <= cfg_data;
                hcd_pkg::CFG_MAX_ACCEL: cfg_reg.max_accel <= cfg_data;
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

    hcd_ctrl #(
        .SUB_STEPS (SUB_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    hcd_dpath #(
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .cfg     (cfg_reg),
        .s_item  (s_data),
        .sts     (sts),
        .m_item  (m_data)
    );

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item taken while another is in flight");

    a_reward_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.reward <= hcd_pkg::RWD_W'(hcd_pkg::Q_ONE)))
        else $error("reward above one");

    a_goal_reward: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.next_status == hcd_pkg::ST_GOAL))
            |-> (m_data.reward == hcd_pkg::RWD_W'(hcd_pkg::Q_ONE)))
        else $error("goal without full reward");

endmodule

FILE: rtl/core/hcd_dpath.sv
// Hill car dynamics step: datapath with scratch memory, multiplier, divider and square root.
// Depends on hcd_pkg; driven by hcd_ctrl through hcd_pkg::cmd_t.
`timescale 1ns / 1ps

module hcd_dpath #(
    parameter int NUM_ACTIONS = hcd_pkg::NUM_ACTIONS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  hcd_pkg::cmd_t cmd,
    input  hcd_pkg::cfg_t cfg,
    input  hcd_pkg::in_t  s_item,
    output hcd_pkg::sts_t sts,
    output hcd_pkg::out_t m_item
);

    localparam longint ACT_DIV = longint'(NUM_ACTIONS - 1);
    localparam logic [36:0] ACT_RCP =
        37'(((longint'(1) << 36) + ACT_DIV - longint'(1)) / ACT_DIV);

    hcd_pkg::in_t  in_reg;
    hcd_pkg::out_t out_reg;
    hcd_pkg::out_t out_next;

    logic signed [31:0] mem [16];
    logic signed [31:0] rda_reg, rdb_reg, opa_reg, opb_reg;
    logic [4:0]         srca_reg, srcb_reg;
    logic signed [31:0] opnd_a, opnd_b;
    logic signed [31:0] x_reg, v_reg;
    logic [3:0]         wrd_reg;

    logic               mul_pend_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] mround;
    logic signed [31:0] mres;

    logic               div_busy_reg, dneg_reg;
    logic [5:0]         div_cnt_reg;
    logic [32:0]        rem_reg;
    logic [55:0]        quo_reg;
    logic [31:0]        dv_reg;
    logic [31:0]        shifted;
    logic [33:0]        diff;
    logic               div_fin;
    logic signed [31:0] dres;
    logic [31:0]        acc_num;
    logic [67:0]        acc_prod;
    logic signed [31:0] acc_res;

    logic               sq_busy_reg;
    logic [4:0]         sq_cnt_reg;
    logic [55:0]        sn_reg, sres_reg, sbit_reg;
    logic [55:0]        strial;
    logic               sq_fin;

    logic [31:0]        absa, absb;
    logic signed [39:0] kp;
    logic signed [31:0] kma_res, sub_res, sel_res, simple_res;
    logic               simple_wr, div_zero, sq_zero, is_start;
    logic               wr_en;
    logic [3:0]         wr_addr;
    logic signed [31:0] wr_data;
    logic [32:0]        av;
    logic [32:0]        rsum;

    function automatic logic signed [31:0] src_val(input logic [4:0] s,
                                                   input logic signed [31:0] m,
                                                   input hcd_pkg::cfg_t c,
                                                   input hcd_pkg::in_t i);
        logic signed [31:0] r;
        if (!s[4]) begin
            r = m;
        end else begin
            case (s)
                hcd_pkg::S_ZERO: r = '0;
                hcd_pkg::S_ONE:  r = hcd_pkg::Q_ONE;
                hcd_pkg::S_TWO:  r = hcd_pkg::Q_TWO;
                hcd_pkg::S_DT:   r = hcd_pkg::Q_DT;
                hcd_pkg::S_G:    r = signed'({1'b0, c.gravity});
                hcd_pkg::S_MS:   r = signed'({1'b0, c.car_mass});
                hcd_pkg::S_INX:  r = i.position;
                hcd_pkg::S_INV:  r = i.velocity;
                default:         r = '0;
            endcase
        end
        return r;
    endfunction

    assign opnd_a = src_val(srca_reg, rda_reg, cfg, in_reg);
    assign opnd_b = src_val(srcb_reg, rdb_reg, cfg, in_reg);

    assign is_start = cmd.start;
    assign absa     = opa_reg[31] ? 32'(-opa_reg) : 32'(opa_reg);
    assign absb     = opb_reg[31] ? 32'(-opb_reg) : 32'(opb_reg);

    assign kp      = signed'({1'b0, cmd.uop.k}) * opa_reg;
    assign kma_res = hcd_pkg::sat_q(64'(kp) + 64'(opb_reg));
    assign sub_res = hcd_pkg::sat_q(64'(opa_reg) - 64'(opb_reg) - 64'(opnd_a));
    assign sel_res = x_reg[31] ? opa_reg : opb_reg;

    assign acc_num  = in_reg.action_index[0] ? {cfg.max_accel, 1'b0} : 32'd0;
    assign acc_prod = 68'(acc_num) * 68'(ACT_RCP);
    assign acc_res  = signed'(acc_prod[67:36] - {1'b0, cfg.max_accel});

    assign div_zero = (cmd.uop.op == hcd_pkg::OP_DIV) && (opb_reg == '0);
    assign sq_zero  = (cmd.uop.op == hcd_pkg::OP_SQRT) && (opa_reg <= 0);

    always_comb begin
        simple_wr  = 1'b0;
        simple_res = kma_res;
        if (is_start) begin
            case (cmd.uop.op)
                hcd_pkg::OP_KMA: begin
                    simple_wr  = 1'b1;
                    simple_res = kma_res;
                end
                hcd_pkg::OP_SUB3: begin
                    simple_wr  = 1'b1;
                    simple_res = sub_res;
                end
                hcd_pkg::OP_SEL: begin
                    simple_wr  = 1'b1;
                    simple_res = sel_res;
                end
                hcd_pkg::OP_ACC: begin
                    simple_wr  = 1'b1;
                    simple_res = acc_res;
                end
                hcd_pkg::OP_DIV: begin
                    simple_wr  = div_zero;
                    simple_res = opa_reg[31] ? hcd_pkg::Q_MIN :
                                 (opa_reg == '0) ? 32'sd0 : hcd_pkg::Q_MAX;
                end
                hcd_pkg::OP_SQRT: begin
                    simple_wr  = sq_zero;
                    simple_res = '0;
                end
                default: begin
                    simple_wr  = 1'b0;
                    simple_res = kma_res;
                end
            endcase
        end
    end

    assign mround = prod_reg + 64'sd8388608;
    assign mres   = hcd_pkg::sat_q(mround >>> 24);

    assign shifted = {rem_reg[30:0], quo_reg[55]};
    assign diff    = {1'b0, rem_reg[31], shifted} - {2'b00, dv_reg};
    assign div_fin = div_busy_reg && (div_cnt_reg == 6'(hcd_pkg::DIV_N));

    always_comb begin
        if (dneg_reg) begin
            dres = (quo_reg > 56'h80000000) ? hcd_pkg::Q_MIN : signed'(32'(-quo_reg[31:0]));
        end else begin
            dres = (quo_reg > 56'h7FFFFFFF) ? hcd_pkg::Q_MAX : signed'(quo_reg[31:0]);
        end
    end

    assign strial = sres_reg + sbit_reg;
    assign sq_fin = sq_busy_reg && (sq_cnt_reg == 5'(hcd_pkg::SQ_N));

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = wrd_reg;
        wr_data = mres;
        if (simple_wr) begin
            wr_addr = cmd.uop.rd[3:0];
            wr_data = simple_res;
        end else if (mul_pend_reg) begin
            wr_data = mres;
        end else if (div_fin) begin
            wr_data = dres;
        end else if (sq_fin) begin
            wr_data = signed'(sres_reg[31:0]);
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_ab) begin
            rda_reg  <= mem[cmd.uop.ra[3:0]];
            rdb_reg  <= mem[cmd.uop.rb[3:0]];
            srca_reg <= cmd.uop.ra;
            srcb_reg <= cmd.uop.rb;
        end else if (cmd.rd_c) begin
            opa_reg  <= opnd_a;
            opb_reg  <= opnd_b;
            rda_reg  <= mem[cmd.uop.rc[3:0]];
            srca_reg <= cmd.uop.rc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_item;
        end
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
        if (wr_en && (wr_addr == hcd_pkg::R_X[3:0])) begin
            x_reg <= wr_data;
        end
        if (wr_en && (wr_addr == hcd_pkg::R_V[3:0])) begin
            v_reg <= wr_data;
        end
        if (is_start) begin
            wrd_reg  <= cmd.uop.rd[3:0];
            prod_reg <= opa_reg * opb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_pend_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            sq_busy_reg  <= 1'b0;
        end else begin
            mul_pend_reg <= is_start && (cmd.uop.op == hcd_pkg::OP_MUL);
            if (is_start && (cmd.uop.op == hcd_pkg::OP_DIV) && !div_zero) begin
                div_busy_reg <= 1'b1;
            end else if (div_fin) begin
                div_busy_reg <= 1'b0;
            end
            if (is_start && (cmd.uop.op == hcd_pkg::OP_SQRT) && !sq_zero) begin
                sq_busy_reg <= 1'b1;
            end else if (sq_fin) begin
                sq_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (is_start) begin
            div_cnt_reg <= '0;
            rem_reg     <= '0;
            quo_reg     <= {absa, 24'd0};
            dv_reg      <= absb;
            dneg_reg    <= opa_reg[31] ^ opb_reg[31];
        end else if (div_busy_reg && !div_fin) begin
            div_cnt_reg <= div_cnt_reg + 6'd1;
            if (!diff[33]) begin
                rem_reg <= diff[32:0];
                quo_reg <= {quo_reg[54:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[31], shifted};
                quo_reg <= {quo_reg[54:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (is_start) begin
            sq_cnt_reg <= '0;
            sn_reg     <= {absa, 24'd0};
            sres_reg   <= '0;
            sbit_reg   <= 56'd1 << 54;
        end else if (sq_busy_reg && !sq_fin) begin
            sq_cnt_reg <= sq_cnt_reg + 5'd1;
            sbit_reg   <= sbit_reg >> 2;
            if (sn_reg >= strial) begin
                sn_reg   <= sn_reg - strial;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end else begin
                sres_reg <= sres_reg >> 1;
            end
        end
    end

    assign av   = v_reg[31] ? 33'(-{v_reg[31], v_reg}) : {1'b0, v_reg};
    assign rsum = {x_reg[31], x_reg} + 33'(hcd_pkg::Q_ONE);

    always_comb begin
        out_next = '0;
        if (in_reg.status != hcd_pkg::ST_RUN) begin
            out_next.next_position = in_reg.position;
            out_next.next_velocity = in_reg.velocity;
            if (in_reg.status == hcd_pkg::ST_GOAL) begin
                out_next.next_status = hcd_pkg::ST_GOAL;
                out_next.reward      = hcd_pkg::RWD_W'(hcd_pkg::Q_ONE);
            end else begin
                out_next.next_status = hcd_pkg::ST_FAIL;
                out_next.reward      = '0;
            end
        end else begin
            out_next.next_position = x_reg;
            out_next.next_velocity = v_reg;
            if (av > {2'b00, cfg.max_speed}) begin
                out_next.next_status = hcd_pkg::ST_FAIL;
                out_next.reward      = '0;
            end else if (x_reg >= hcd_pkg::Q_ONE) begin
                out_next.next_status = hcd_pkg::ST_GOAL;
                out_next.reward      = hcd_pkg::RWD_W'(hcd_pkg::Q_ONE);
            end else if (x_reg < -hcd_pkg::Q_ONE) begin
                out_next.next_status = hcd_pkg::ST_FAIL;
                out_next.reward      = '0;
            end else begin
                out_next.next_status = hcd_pkg::ST_RUN;
                out_next.reward      = rsum[25:1];
            end
        end
    end

    assign sts.done = wr_en;
    assign sts.term = (in_reg.status != hcd_pkg::ST_RUN);
    assign m_item   = out_reg;

endmodule

FILE: rtl/core/hcd_ctrl.sv
// Hill car dynamics step: controller stepping the microprogram and the sub-step loop.
// Depends on hcd_pkg; commands hcd_dpath, owns the result valid flag.
`timescale 1ns / 1ps

module hcd_ctrl #(
    parameter int SUB_STEPS = hcd_pkg::SUB_STEPS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  hcd_pkg::sts_t sts,
    output hcd_pkg::cmd_t cmd
);

    localparam int CNT_W = (SUB_STEPS > 1) ? $clog2(SUB_STEPS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_RDAB  = 3'd2;
    localparam logic [2:0] S_RDC   = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]               state_reg, state_next;
    logic [hcd_pkg::PC_W-1:0] pc_reg, pc_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.uop      = hcd_pkg::prog(pc_reg);
        s_ready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                if (s_valid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                pc_next    = '0;
                cnt_next   = '0;
                state_next = sts.term ? S_DONE : S_RDAB;
            end
            S_RDAB: begin
                cmd.rd_ab  = 1'b1;
                state_next = S_RDC;
            end
            S_RDC: begin
                cmd.rd_c   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC, S_WAIT: begin
                cmd.start = (state_reg == S_EXEC);
                if (sts.done) begin
                    state_next = S_RDAB;
                    if (pc_reg == hcd_pkg::PC_LAST) begin
                        if (cnt_reg == CNT_W'(SUB_STEPS - 1)) begin
                            state_next = S_DONE;
                        end else begin
                            pc_next  = hcd_pkg::PC_BODY;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end else begin
                        pc_next = pc_reg + 1'b1;
                    end
                end else begin
                    state_next = S_WAIT;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pc_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
